### hdl/ckstep_pkg.sv
// ----------------------------------------------------------------------------
// ckstep_pkg
// Shared types, constants, microprogram and arithmetic helpers for the
// clamped 2-D kinematics step block.
// ----------------------------------------------------------------------------
package ckstep_pkg;

   localparam int STEP_W = 3;
   localparam int PROD_W = 50;
   localparam int REQ_W  = 152;
   localparam int RSP_W  = 192;
   localparam int ADDR_W = 3;

   localparam logic [ADDR_W-1:0] REG_ACCEL_X      = 3'd0;
   localparam logic [ADDR_W-1:0] REG_ACCEL_Y      = 3'd1;
   localparam logic [ADDR_W-1:0] REG_MAX_SPEED_X  = 3'd2;
   localparam logic [ADDR_W-1:0] REG_MAX_SPEED_Y  = 3'd3;
   localparam logic [ADDR_W-1:0] REG_BOUND_BOTTOM = 3'd4;
   localparam logic [ADDR_W-1:0] REG_BOUND_TOP    = 3'd5;
   localparam logic [ADDR_W-1:0] REG_BOUND_RIGHT  = 3'd6;
   localparam logic [ADDR_W-1:0] REG_BOUND_LEFT   = 3'd7;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   localparam logic OP_STEP = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   localparam logic [STEP_W-1:0] STEP_MUL_AX  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_MUL_AY  = 3'd1;
   localparam logic [STEP_W-1:0] STEP_MUL_SX  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_MUL_SY  = 3'd3;
   localparam logic [STEP_W-1:0] STEP_MOVE_Y  = 3'd4;
   localparam logic [STEP_W-1:0] STEP_LOAD    = 3'd5;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_AX,
      MUL_AY,
      MUL_SX,
      MUL_SY
   } mul_sel_type;

   typedef struct packed {
      mul_sel_type       mul_sel;
      logic              acc_x;
      logic              acc_y;
      logic              move_x;
      logic              move_y;
      logic              load;
      logic              done;
      logic              jmp_load;
      logic [STEP_W-1:0] target;
   } ctrl_word_type;

   typedef struct packed {
      logic          take;
      logic          exec;
      ctrl_word_type cw;
   } dp_ctrl_type;

   localparam ctrl_word_type CW_NOP = '{
      mul_sel: MUL_NONE, acc_x: 1'b0, acc_y: 1'b0, move_x: 1'b0, move_y: 1'b0,
      load: 1'b0, done: 1'b0, jmp_load: 1'b0, target: STEP_MUL_AX};

   function automatic ctrl_word_type prog_word(input logic [STEP_W-1:0] step);
      ctrl_word_type cw;
      cw = CW_NOP;
      case (step)
         STEP_MUL_AX: begin
            cw.mul_sel  = MUL_AX;
            cw.jmp_load = 1'b1;
            cw.target   = STEP_LOAD;
         end
         STEP_MUL_AY: begin
            cw.mul_sel = MUL_AY;
            cw.acc_x   = 1'b1;
         end
         STEP_MUL_SX: begin
            cw.mul_sel = MUL_SX;
            cw.acc_y   = 1'b1;
         end
         STEP_MUL_SY: begin
            cw.mul_sel = MUL_SY;
            cw.move_x  = 1'b1;
         end
         STEP_MOVE_Y: begin
            cw.move_y = 1'b1;
            cw.done   = 1'b1;
         end
         STEP_LOAD: begin
            cw.load = 1'b1;
            cw.done = 1'b1;
         end
         default: begin
            cw.done = 1'b1;
         end
      endcase
      return cw;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'(Q_MAX)) begin
         r = Q_MAX;
      end else if (v < 34'(Q_MIN)) begin
         r = Q_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] accel_axis(
      input logic signed [31:0]       v,
      input logic signed [31:0]       a,
      input logic        [30:0]       vmax,
      input logic signed [PROD_W-1:0] prod
   );
      logic signed [PROD_W-1:0] rnd;
      logic signed [32:0]       inc;
      logic signed [32:0]       vm;
      logic signed [32:0]       v33;
      logic signed [32:0]       nv33;
      logic signed [31:0]       nv;
      logic                     go;
      rnd  = prod + PROD_W'(32768);
      inc  = rnd[48:16];
      vm   = {2'b00, vmax};
      v33  = {v[31], v};
      go   = (a > 32'sd0 && v33 < vm) || (a < 32'sd0 && v33 > -vm);
      nv   = go ? sat32({{2{v[31]}}, v} + {inc[32], inc}) : v;
      nv33 = {nv[31], nv};
      if (nv33 > vm) begin
         nv = vm[31:0];
      end
      return nv;
   endfunction

   function automatic logic signed [31:0] move_axis(
      input logic signed [31:0]       p,
      input logic signed [PROD_W-1:0] prod
   );
      logic signed [PROD_W-1:0] rnd;
      logic signed [32:0]       inc;
      rnd = prod + PROD_W'(65536);
      inc = rnd[49:17];
      return sat32({{2{p[31]}}, p} + {inc[32], inc});
   endfunction

endpackage

### hdl/ckstep_dp.sv
// ----------------------------------------------------------------------------
// ckstep_dp
// Datapath: configuration registers, kinematic state, one shared multiplier
// and the accelerate, integrate and clamp units driven by the control word.
// ----------------------------------------------------------------------------
module ckstep_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ckstep_pkg::dp_ctrl_type              ctrl,
   input  logic                                 csr_we,
   input  logic [ckstep_pkg::ADDR_W-1:0]        csr_addr,
   input  logic [31:0]                          csr_wdata,
   input  logic [ckstep_pkg::REQ_W-1:0]         req_tdata,
   output logic [ckstep_pkg::RSP_W-1:0]         rsp_tdata
);

   logic signed [31:0] accel_x_ff, accel_y_ff;
   logic        [30:0] max_speed_x_ff, max_speed_y_ff;
   logic signed [31:0] bound_bottom_ff, bound_top_ff, bound_right_ff, bound_left_ff;

   logic signed [31:0] pos_x_ff, pos_y_ff, last_x_ff, last_y_ff, vel_x_ff, vel_y_ff;
   logic signed [31:0] pos_x_in, pos_y_in, last_x_in, last_y_in, vel_x_in, vel_y_in;
   logic signed [31:0] vold_x_ff, vold_y_ff;

   logic        [15:0] dt_ff;
   logic               apply_ff;
   logic signed [31:0] ld_pos_x_ff, ld_pos_y_ff, ld_vel_x_ff, ld_vel_y_ff;

   logic signed [ckstep_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [32:0]                   mul_a;
   logic signed [16:0]                   dt_s;

   logic [ckstep_pkg::RSP_W-1:0] rsp_tdata_ff;

   logic signed [31:0] px_t, py_t;
   logic               hit_x, hit_y;

   assign dt_s = {1'b0, dt_ff};

   always_comb begin
      case (ctrl.cw.mul_sel)
         ckstep_pkg::MUL_AX: mul_a = {accel_x_ff[31], accel_x_ff};
         ckstep_pkg::MUL_AY: mul_a = {accel_y_ff[31], accel_y_ff};
         ckstep_pkg::MUL_SX: mul_a = {vold_x_ff[31], vold_x_ff} + {vel_x_ff[31], vel_x_ff};
         ckstep_pkg::MUL_SY: mul_a = {vold_y_ff[31], vold_y_ff} + {vel_y_ff[31], vel_y_ff};
         default:            mul_a = '0;
      endcase
      prod_in = mul_a * dt_s;
   end

   always_comb begin
      pos_x_in  = pos_x_ff;
      pos_y_in  = pos_y_ff;
      last_x_in = last_x_ff;
      last_y_in = last_y_ff;
      vel_x_in  = vel_x_ff;
      vel_y_in  = vel_y_ff;
      px_t      = ckstep_pkg::move_axis(pos_x_ff, prod_ff);
      py_t      = ckstep_pkg::move_axis(pos_y_ff, prod_ff);
      hit_x     = 1'b0;
      hit_y     = 1'b0;

      if (px_t > bound_right_ff) begin
         px_t  = bound_right_ff;
         hit_x = 1'b1;
      end
      if (px_t < bound_left_ff) begin
         px_t  = bound_left_ff;
         hit_x = 1'b1;
      end
      if (py_t > bound_bottom_ff) begin
         py_t  = bound_bottom_ff;
         hit_y = 1'b1;
      end
      if (py_t < bound_top_ff) begin
         py_t  = bound_top_ff;
         hit_y = 1'b1;
      end

      if (ctrl.cw.acc_x && apply_ff) begin
         vel_x_in = ckstep_pkg::accel_axis(vel_x_ff, accel_x_ff, max_speed_x_ff, prod_ff);
      end
      if (ctrl.cw.acc_y && apply_ff) begin
         vel_y_in = ckstep_pkg::accel_axis(vel_y_ff, accel_y_ff, max_speed_y_ff, prod_ff);
      end
      if (ctrl.cw.move_x) begin
         pos_x_in  = px_t;
         last_x_in = hit_x ? px_t : pos_x_ff;
      end
      if (ctrl.cw.move_y) begin
         pos_y_in  = py_t;
         last_y_in = hit_y ? py_t : pos_y_ff;
         vel_y_in  = hit_y ? 32'sd0 : vel_y_ff;
      end
      if (ctrl.cw.load) begin
         pos_x_in  = ld_pos_x_ff;
         pos_y_in  = ld_pos_y_ff;
         last_x_in = ld_pos_x_ff;
         last_y_in = ld_pos_y_ff;
         vel_x_in  = ld_vel_x_ff;
         vel_y_in  = ld_vel_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_x_ff      <= '0;
         accel_y_ff      <= '0;
         max_speed_x_ff  <= '1;
         max_speed_y_ff  <= '1;
         bound_bottom_ff <= ckstep_pkg::Q_MAX;
         bound_top_ff    <= ckstep_pkg::Q_MIN;
         bound_right_ff  <= ckstep_pkg::Q_MAX;
         bound_left_ff   <= ckstep_pkg::Q_MIN;
         pos_x_ff        <= '0;
         pos_y_ff        <= '0;
         last_x_ff       <= '0;
         last_y_ff       <= '0;
         vel_x_ff        <= '0;
         vel_y_ff        <= '0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               ckstep_pkg::REG_ACCEL_X:      accel_x_ff      <= csr_wdata;
               ckstep_pkg::REG_ACCEL_Y:      accel_y_ff      <= csr_wdata;
               ckstep_pkg::REG_MAX_SPEED_X:  max_speed_x_ff  <= csr_wdata[30:0];
               ckstep_pkg::REG_MAX_SPEED_Y:  max_speed_y_ff  <= csr_wdata[30:0];
               ckstep_pkg::REG_BOUND_BOTTOM: bound_bottom_ff <= csr_wdata;
               ckstep_pkg::REG_BOUND_TOP:    bound_top_ff    <= csr_wdata;
               ckstep_pkg::REG_BOUND_RIGHT:  bound_right_ff  <= csr_wdata;
               ckstep_pkg::REG_BOUND_LEFT:   bound_left_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (ctrl.exec) begin
            pos_x_ff  <= pos_x_in;
            pos_y_ff  <= pos_y_in;
            last_x_ff <= last_x_in;
            last_y_ff <= last_y_in;
            vel_x_ff  <= vel_x_in;
            vel_y_ff  <= vel_y_in;
         end
      end
   end

   // payload: latch the item, hold the old velocity, advance the product, capture the result
   always_ff @(posedge clock) begin
      if (ctrl.take) begin
         dt_ff       <= req_tdata[15:0];
         apply_ff    <= req_tdata[16];
         ld_pos_x_ff <= req_tdata[48:17];
         ld_pos_y_ff <= req_tdata[80:49];
         ld_vel_x_ff <= req_tdata[112:81];
         ld_vel_y_ff <= req_tdata[144:113];
         vold_x_ff   <= vel_x_ff;
         vold_y_ff   <= vel_y_ff;
      end
      if (ctrl.exec) begin
         prod_ff <= prod_in;
      end
      if (ctrl.exec && ctrl.cw.done) begin
         rsp_tdata_ff <= {vel_y_in, vel_x_in, last_y_in, last_x_in, pos_y_in, pos_x_in};
      end
   end

   assign rsp_tdata = rsp_tdata_ff;

endmodule

### hdl/clamped_2d_kinematics_step.sv
// ----------------------------------------------------------------------------
// clamped_2d_kinematics_step
// Two-axis Q16.16 kinematic integrator with acceleration, speed cap and
// clamped position bounds, run by a small microprogram.
// ----------------------------------------------------------------------------
// A step item runs five microprogram steps through one shared 33x17
// multiplier (X and Y acceleration products, then X and Y mean-velocity
// products), and its result is registered when the last step executes. A
// load item runs the first step and then jumps to the load step. A new item
// is accepted only while idle. The result sits in an output register, so the
// next item may be accepted while it waits; a finished item holds in its last
// step only if the previous result has still not been taken.
module clamped_2d_kinematics_step (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // step_time[15:0], apply_accel[16], load_pos_x[48:17], load_pos_y[80:49],
   // load_vel_x[112:81], load_vel_y[144:113], zero fill [151:145]
   input  logic [ckstep_pkg::REQ_W-1:0]      req_tdata,
   // op[0]
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // pos_x[31:0], pos_y[63:32], prev_pos_x[95:64], prev_pos_y[127:96],
   // vel_x[159:128], vel_y[191:160]
   output logic [ckstep_pkg::RSP_W-1:0]      rsp_tdata,
   input  logic                              csr_we,
   input  logic [ckstep_pkg::ADDR_W-1:0]     csr_addr,
   input  logic [31:0]                       csr_wdata
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type                       state_ff;
   logic [ckstep_pkg::STEP_W-1:0]   step_ff;
   logic                            op_ff;
   logic                            rsp_valid_ff;

   ckstep_pkg::ctrl_word_type       cw;
   ckstep_pkg::dp_ctrl_type         ctrl;
   logic                            take;
   logic                            stall;
   logic                            exec;

   assign cw         = ckstep_pkg::prog_word(step_ff);
   assign req_tready = (state_ff == ST_IDLE);
   assign take       = req_tvalid && req_tready;
   assign stall      = cw.done && rsp_valid_ff && !rsp_tready;
   assign exec       = (state_ff == ST_RUN) && !stall;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      ctrl.take = take;
      ctrl.exec = exec;
      ctrl.cw   = cw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= ckstep_pkg::STEP_MUL_AX;
         op_ff        <= ckstep_pkg::OP_STEP;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (exec && cw.done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (take) begin
                  state_ff <= ST_RUN;
                  step_ff  <= ckstep_pkg::STEP_MUL_AX;
                  op_ff    <= req_tuser;
               end
            end
            ST_RUN: begin
               if (exec) begin
                  if (cw.done) begin
                     state_ff <= ST_IDLE;
                  end else if (cw.jmp_load && op_ff == ckstep_pkg::OP_LOAD) begin
                     step_ff <= cw.target;
                  end else begin
                     step_ff <= step_ff + 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   ckstep_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule
